// ===== design/cvh_pkg.sv =====
// shared constants, types and codes for the 2d gift-wrap convex hull core
package cvh_pkg;

   // point store sizing
   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 24;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // arithmetic widths
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int CMP_W  = PROD_W + 2;

   // stream field layout
   localparam int FIELD_COORD_W = 24;
   localparam int SEED_W        = 6;
   localparam int HULL_IDX_W    = 6;
   localparam int STATUS_W      = 2;
   localparam int TOL_W         = 24;
   localparam int X_LSB         = 0;
   localparam int Y_LSB         = X_LSB + FIELD_COORD_W;
   localparam int FROM_LSB      = Y_LSB + FIELD_COORD_W;
   localparam int TO_LSB        = FROM_LSB + SEED_W;
   localparam int REQ_DATA_W    = 64;
   localparam int RSP_DATA_W    = 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [CMP_W-1:0]      cmp_type;
   typedef logic [PROD_W-1:0]            len_type;
   typedef logic [TOL_W-1:0]             tol_type;
   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic [CNT_W-1:0]             cnt_type;

   // final result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_TOO_LONG = 2'd1,
      ST_NO_SUCC  = 2'd2
   } status_type;

   // status of the cross product pipeline
   typedef struct packed {
      logic busy;
      logic hit;
   } cross_stat_type;

endpackage

// ===== design/cvh_point_mem.sv =====
// point coordinate store, one write port and one registered read port
module cvh_point_mem (
   input  logic              clock,
   input  logic              wr_en,
   input  cvh_pkg::idx_type   wr_addr,
   input  cvh_pkg::coord_type wr_x,
   input  cvh_pkg::coord_type wr_y,
   input  cvh_pkg::idx_type   rd_addr,
   output cvh_pkg::coord_type rd_x,
   output cvh_pkg::coord_type rd_y
);
   import cvh_pkg::*;

   coord_type x_mem [MAX_POINTS];
   coord_type y_mem [MAX_POINTS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= wr_x;
         y_mem[wr_addr] <= wr_y;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_x <= x_mem[rd_addr];
      rd_y <= y_mem[rd_addr];
   end

endmodule

// ===== design/cvh_cross_pipe.sv =====
// orientation test pipeline: flags points right of the candidate edge
module cvh_cross_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    issue,
   input  cvh_pkg::coord_type       rd_x,
   input  cvh_pkg::coord_type       rd_y,
   input  cvh_pkg::coord_type       xc,
   input  cvh_pkg::coord_type       yc,
   input  cvh_pkg::diff_type        dx,
   input  cvh_pkg::diff_type        dy,
   input  cvh_pkg::tol_type         tol,
   output cvh_pkg::cross_stat_type  stat
);
   import cvh_pkg::*;

   logic     v0_ff, v1_ff, v2_ff;
   logic     right_ff;
   prod_type p1_ff, p2_ff;
   diff_type ex, ey;
   cmp_type  cmp_sum;

   // offsets of the tested point from the current vertex
   assign ex = diff_type'(rd_x) - diff_type'(xc);
   assign ey = diff_type'(rd_y) - diff_type'(yc);

   // cross product plus tolerance, negative means outside
   assign cmp_sum = cmp_type'(p1_ff) - cmp_type'(p2_ff) + cmp_type'(tol);

   // valid tags follow the memory read and the two stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   // products, then sign of the difference
   always_ff @(posedge clock) begin
      p1_ff    <= dx * ey;
      p2_ff    <= dy * ex;
      right_ff <= cmp_sum[CMP_W-1];
   end

   assign stat.busy = v0_ff | v1_ff | v2_ff;
   assign stat.hit  = v2_ff & right_ff;

endmodule

// ===== design/convex_hull_2d_gift_wrap_core.sv =====
// top level of the 2d gift-wrap convex hull core
//
// Points arrive on the req_ stream, one word per cycle, and are written to an
// on-chip store in load order (index 0 first). The word with req_tlast high
// is stored too and starts the wrap; req_tuser selects seeded mode, in which
// seed_to is reported first, the wrap continues from seed_from and stops on
// returning to seed_to. Unseeded mode starts at the least-x, then least-y
// point. Words beyond the store depth are dropped.
// Hull vertex indices leave on the rsp_ stream in wrap order; rsp_tlast marks
// the final one and rsp_tuser carries its status (ok, hull too long, or no
// successor found).
// During the wrap req_tready is low. How long each hull vertex takes is set by
// the single read port of the point store, which is swept once per candidate
// through the cross product pipeline; the start-point search sweeps it once.
// A stalled receiver holds the output register and pauses the wrap at the
// next vertex. The csr_ port writes the cross tolerance (reset value 1); it is
// to be used only while the core is idle, and the core itself has no check for it.
// Synchronous reset empties the store and returns the core to loading; no
// clearing pass is needed.
module convex_hull_2d_gift_wrap_core (
   input  logic                             clock,
   input  logic                             reset,
   // x_coord, y_coord, seed_from, seed_to, zero pad
   input  logic [cvh_pkg::REQ_DATA_W-1:0]  req_tdata,
   // seeded
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // hull_index, zero pad
   output logic [cvh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic [cvh_pkg::STATUS_W-1:0]    rsp_tuser,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wr_en,
   input  logic [cvh_pkg::TOL_W-1:0]       csr_wr_data
);
   import cvh_pkg::*;

   typedef enum logic [11:0] {
      S_LOAD   = 12'b0000_0000_0001,
      S_MIN    = 12'b0000_0000_0010,
      S_CHECK  = 12'b0000_0000_0100,
      S_EMIT   = 12'b0000_0000_1000,
      S_RDC    = 12'b0000_0001_0000,
      S_RDCW   = 12'b0000_0010_0000,
      S_CAND   = 12'b0000_0100_0000,
      S_CWAIT  = 12'b0000_1000_0000,
      S_JSCAN  = 12'b0001_0000_0000,
      S_DRAIN  = 12'b0010_0000_0000,
      S_NEXT   = 12'b0100_0000_0000,
      S_FINISH = 12'b1000_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   cnt_type    cnt_ff, cnt_in;
   cnt_type    hull_ff, hull_in;
   idx_type    cur_ff, cur_in;
   idx_type    stop_ff, stop_in;
   idx_type    pend_ff, pend_in;
   logic       pend_vld_ff, pend_vld_in;
   cnt_type    scan_ff, scan_in;
   cnt_type    cand_ff, cand_in;
   logic       rdv_ff, rdv_in;
   idx_type    rd_idx_ff, rd_idx_in;
   idx_type    min_idx_ff, min_idx_in;
   coord_type  min_x_ff, min_x_in;
   coord_type  min_y_ff, min_y_in;
   coord_type  xc_ff, xc_in;
   coord_type  yc_ff, yc_in;
   diff_type   dx_ff, dx_in;
   diff_type   dy_ff, dy_in;
   prod_type   sqx_ff, sqx_in;
   prod_type   sqy_ff, sqy_in;
   logic       clear_ff, clear_in;
   idx_type    best_ff, best_in;
   logic       best_vld_ff, best_vld_in;
   len_type    best_dist_ff, best_dist_in;
   status_type stat_ff, stat_in;
   tol_type    tol_ff, tol_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic [HULL_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic       rsp_last_ff, rsp_last_in;
   status_type rsp_stat_ff, rsp_stat_in;

   logic           accept;
   logic           out_free;
   logic           mem_wr_en;
   idx_type        mem_rd_addr;
   coord_type      rd_x, rd_y;
   coord_type      req_x, req_y;
   logic [SEED_W-1:0] seed_from, seed_to;
   cnt_type        cnt_new;
   logic           seed_ok;
   logic           issue;
   logic           min_less;
   len_type        len_sum;
   cross_stat_type xst;

   // request word unpacking
   assign req_x     = req_tdata[X_LSB +: COORD_BITS];
   assign req_y     = req_tdata[Y_LSB +: COORD_BITS];
   assign seed_from = req_tdata[FROM_LSB +: SEED_W];
   assign seed_to   = req_tdata[TO_LSB +: SEED_W];

   assign req_tready = (state_ff == S_LOAD);
   assign accept     = req_tvalid & req_tready;
   assign mem_wr_en  = accept && (cnt_ff < CNT_W'(MAX_POINTS));
   assign cnt_new    = cnt_ff + CNT_W'(mem_wr_en);
   assign seed_ok    = ((SEED_W+1)'(seed_from) < (SEED_W+1)'(cnt_new)) &&
                       ((SEED_W+1)'(seed_to) < (SEED_W+1)'(cnt_new));
   assign out_free   = !rsp_vld_ff || rsp_tready;

   // start point ordering and candidate length
   assign min_less = (rd_x < min_x_ff) || ((rd_x == min_x_ff) && (rd_y < min_y_ff));
   assign len_sum  = len_type'(sqx_ff) + len_type'(sqy_ff);
   assign sqx_in   = dx_ff * dx_ff;
   assign sqy_in   = dy_ff * dy_ff;

   cvh_point_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_x    (req_x),
      .wr_y    (req_y),
      .rd_addr (mem_rd_addr),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   cvh_cross_pipe u_cross (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .rd_x  (rd_x),
      .rd_y  (rd_y),
      .xc    (xc_ff),
      .yc    (yc_ff),
      .dx    (dx_ff),
      .dy    (dy_ff),
      .tol   (tol_ff),
      .stat  (xst)
   );

   // wrap sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      hull_in      = hull_ff;
      cur_in       = cur_ff;
      stop_in      = stop_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      scan_in      = scan_ff;
      cand_in      = cand_ff;
      rdv_in       = 1'b0;
      rd_idx_in    = rd_idx_ff;
      min_idx_in   = min_idx_ff;
      min_x_in     = min_x_ff;
      min_y_in     = min_y_ff;
      xc_in        = xc_ff;
      yc_in        = yc_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      clear_in     = clear_ff & ~xst.hit;
      best_in      = best_ff;
      best_vld_in  = best_vld_ff;
      best_dist_in = best_dist_ff;
      stat_in      = stat_ff;
      tol_in       = csr_wr_en ? csr_wr_data : tol_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_stat_in  = rsp_stat_ff;
      mem_rd_addr  = '0;
      issue        = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               cnt_in = cnt_new;
               if (req_tlast) begin
                  if (req_tuser && seed_ok) begin
                     pend_in     = IDX_W'(seed_to);
                     pend_vld_in = 1'b1;
                     hull_in     = CNT_W'(1);
                     stop_in     = IDX_W'(seed_to);
                     cur_in      = IDX_W'(seed_from);
                     state_in    = S_CHECK;
                  end else begin
                     pend_vld_in = 1'b0;
                     hull_in     = '0;
                     scan_in     = '0;
                     state_in    = S_MIN;
                  end
               end
            end
         end
         S_MIN: begin
            // track the least point over the returning reads
            if (rdv_ff && ((rd_idx_ff == '0) || min_less)) begin
               min_x_in   = rd_x;
               min_y_in   = rd_y;
               min_idx_in = rd_idx_ff;
            end
            if (scan_ff < cnt_ff) begin
               mem_rd_addr = scan_ff[IDX_W-1:0];
               rdv_in      = 1'b1;
               rd_idx_in   = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
            end else if (!rdv_ff) begin
               cur_in   = min_idx_ff;
               stop_in  = min_idx_ff;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (hull_ff >= cnt_ff) begin
               stat_in  = ST_TOO_LONG;
               state_in = S_FINISH;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // the held vertex leaves once the next one is known
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  rsp_vld_in  = 1'b1;
                  rsp_idx_in  = HULL_IDX_W'(pend_ff);
                  rsp_last_in = 1'b0;
                  rsp_stat_in = ST_OK;
               end
               pend_in     = cur_ff;
               pend_vld_in = 1'b1;
               hull_in     = hull_ff + CNT_W'(1);
               state_in    = S_RDC;
            end
         end
         S_RDC: begin
            mem_rd_addr = cur_ff;
            state_in    = S_RDCW;
         end
         S_RDCW: begin
            xc_in        = rd_x;
            yc_in        = rd_y;
            cand_in      = '0;
            best_vld_in  = 1'b0;
            best_dist_in = '0;
            state_in     = S_CAND;
         end
         S_CAND: begin
            if (cand_ff >= cnt_ff) begin
               state_in = S_NEXT;
            end else if (cand_ff[IDX_W-1:0] == cur_ff) begin
               cand_in = cand_ff + CNT_W'(1);
            end else begin
               mem_rd_addr = cand_ff[IDX_W-1:0];
               state_in    = S_CWAIT;
            end
         end
         S_CWAIT: begin
            dx_in    = diff_type'(rd_x) - diff_type'(xc_ff);
            dy_in    = diff_type'(rd_y) - diff_type'(yc_ff);
            clear_in = 1'b1;
            scan_in  = '0;
            state_in = S_JSCAN;
         end
         S_JSCAN: begin
            // sweep every other point through the cross product pipeline
            if (scan_ff < cnt_ff) begin
               mem_rd_addr = scan_ff[IDX_W-1:0];
               issue       = (scan_ff[IDX_W-1:0] != cur_ff) &&
                             (scan_ff != cand_ff);
               scan_in     = scan_ff + CNT_W'(1);
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!xst.busy) begin
               if (clear_ff && (best_dist_ff < len_sum)) begin
                  best_in      = cand_ff[IDX_W-1:0];
                  best_dist_in = len_sum;
                  best_vld_in  = 1'b1;
               end
               cand_in  = cand_ff + CNT_W'(1);
               state_in = S_CAND;
            end
         end
         S_NEXT: begin
            if (!best_vld_ff) begin
               stat_in  = ST_NO_SUCC;
               state_in = S_FINISH;
            end else if (best_ff == stop_ff) begin
               cur_in   = best_ff;
               stat_in  = ST_OK;
               state_in = S_FINISH;
            end else begin
               cur_in   = best_ff;
               state_in = S_CHECK;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_idx_in  = HULL_IDX_W'(pend_ff);
               rsp_last_in = 1'b1;
               rsp_stat_in = stat_ff;
               pend_vld_in = 1'b0;
               cnt_in      = '0;
               state_in    = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         cnt_ff      <= '0;
         hull_ff     <= '0;
         cur_ff      <= '0;
         stop_ff     <= '0;
         pend_vld_ff <= 1'b0;
         rdv_ff      <= 1'b0;
         best_vld_ff <= 1'b0;
         tol_ff      <= TOL_W'(1);
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         hull_ff     <= hull_in;
         cur_ff      <= cur_in;
         stop_ff     <= stop_in;
         pend_vld_ff <= pend_vld_in;
         rdv_ff      <= rdv_in;
         best_vld_ff <= best_vld_in;
         tol_ff      <= tol_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      scan_ff      <= scan_in;
      cand_ff      <= cand_in;
      rd_idx_ff    <= rd_idx_in;
      min_idx_ff   <= min_idx_in;
      min_x_ff     <= min_x_in;
      min_y_ff     <= min_y_in;
      xc_ff        <= xc_in;
      yc_ff        <= yc_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      clear_ff     <= clear_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      stat_ff      <= stat_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   // result word packing
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_idx_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_stat_ff;

endmodule

// ===== tb/tb_convex_hull_2d_gift_wrap_core.sv =====
// testbench for the gift-wrap hull core: streams point sets, checks hull words
`timescale 1ns / 100ps

module tb_convex_hull_2d_gift_wrap_core;
   import cvh_pkg::*;

   localparam int STALL_LIMIT = 60000;
   localparam int SETTLE_CYCLES = 20;

   // one hull word as it leaves the core
   typedef struct {
      idx_type    vtx;
      logic       is_last;
      status_type status;
   } vertex_word_type;

   // how the seeding edge of a set is chosen
   typedef enum int {SEED_NONE, SEED_HULL_EDGE, SEED_IN_RANGE, SEED_ANY} seed_mode_type;

   // shape of a random point cloud
   typedef enum int {CLOUD_WIDE, CLOUD_BOX, CLOUD_LATTICE, CLOUD_CLUSTER} cloud_type;

   // hull predictor and store of expected vertices
   class hull_scoreboard;
      longint          store_x[$];
      longint          store_y[$];
      longint          tolerance;
      vertex_word_type expected_hull[$];
      int              errors;

      function new();
         tolerance = 1;
         errors = 0;
      endfunction

      function void set_tolerance(tol_type value);
         tolerance = longint'(value);
      endfunction

      function int pending();
         return expected_hull.size();
      endfunction

      // farthest candidate with no point beyond the tolerance on its right
      function int next_vertex(longint px[$], longint py[$], int cur);
         longint dx, dy, cr, len, top_len;
         int     best;
         bit     clear;
         best = MAX_POINTS;
         top_len = 0;
         for (int i = 0; i < px.size(); i++) begin
            if (i == cur) continue;
            dx = px[i] - px[cur];
            dy = py[i] - py[cur];
            clear = 1'b1;
            for (int j = 0; j < px.size() && clear; j++) begin
               if (j == cur || j == i) continue;
               cr = dx * (py[j] - py[cur]) - dy * (px[j] - px[cur]);
               if (cr < -tolerance) clear = 1'b0;
            end
            if (clear) begin
               len = dx * dx + dy * dy;
               if (len > top_len) begin
                  top_len = len;
                  best = i;
               end
            end
         end
         return best;
      endfunction

      // full wrap of one point set
      function void trace_hull(longint px[$], longint py[$], bit seeded, int from, int to,
                               output vertex_word_type hull[$]);
         int         n, cur, stop, succ;
         status_type code;
         n = px.size();
         hull = {};
         code = ST_OK;
         if (seeded && from < n && to < n) begin
            hull.push_back('{vtx: idx_type'(to), is_last: 1'b0, status: ST_OK});
            stop = to;
            cur = from;
         end else begin
            cur = 0;
            for (int i = 1; i < n; i++)
               if (px[i] < px[cur] || (px[i] == px[cur] && py[i] < py[cur])) cur = i;
            stop = cur;
         end
         while (1) begin
            if (hull.size() >= n) begin
               code = ST_TOO_LONG;
               break;
            end
            hull.push_back('{vtx: idx_type'(cur), is_last: 1'b0, status: ST_OK});
            succ = next_vertex(px, py, cur);
            if (succ >= MAX_POINTS) begin
               code = ST_NO_SUCC;
               break;
            end
            cur = succ;
            if (cur == stop) break;
         end
         hull[$].is_last = 1'b1;
         hull[$].status = code;
      endfunction

      // accepted point word; the last one of a set yields the hull
      function void note_point(coord_type x, coord_type y, logic last, logic seeded,
                               idx_type from, idx_type to);
         vertex_word_type hull[$];
         if (store_x.size() < MAX_POINTS) begin
            store_x.push_back(longint'(x));
            store_y.push_back(longint'(y));
         end
         if (last) begin
            trace_hull(store_x, store_y, seeded, from, to, hull);
            expected_hull = {expected_hull, hull};
            store_x = {};
            store_y = {};
         end
      endfunction

      function void check_result(idx_type vtx, logic is_last, status_type status);
         vertex_word_type want;
         if (expected_hull.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected hull word: vertex %0d last %0b status %0d",
                        vtx, is_last, status);
            return;
         end
         want = expected_hull.pop_front();
         if (want.vtx !== vtx || want.is_last !== is_last || want.status !== status) begin
            errors++;
            if (errors <= 10)
               $display({"hull word mismatch: expected vertex %0d last %0b status %0d, ",
                         "got vertex %0d last %0b status %0d"},
                        want.vtx, want.is_last, want.status, vtx, is_last, status);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en = 1'b0;
   logic [TOL_W-1:0]      csr_wr_data = '0;

   hull_scoreboard sb;
   bit             steady = 1'b0;
   int             idle_cycles = 0;
   coord_type      set_x[$];
   coord_type      set_y[$];

   convex_hull_2d_gift_wrap_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // receiver stalls at random unless in the steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 29);
   end

   // check every accepted hull word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[HULL_IDX_W-1:0], rsp_tlast, status_type'(rsp_tuser));
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one point word, with random idle cycles ahead of it outside the steady stretch
   task automatic send_point(coord_type x, coord_type y, logic last, logic seeded,
                             idx_type from, idx_type to);
      logic [REQ_DATA_W-1:0] packed_word;
      while (!steady && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      packed_word = '0;
      packed_word[X_LSB +: FIELD_COORD_W] = x;
      packed_word[Y_LSB +: FIELD_COORD_W] = y;
      packed_word[FROM_LSB +: SEED_W] = from;
      packed_word[TO_LSB +: SEED_W] = to;
      req_tdata <= packed_word;
      req_tuser <= seeded;
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_point(x, y, last, seeded, from, to);
   endtask

   // stream the current set, then wait for its hull to drain
   task automatic send_set(bit seeded, int from, int to);
      int n;
      n = set_x.size();
      for (int k = 0; k < n; k++) begin
         if (k == n - 1)
            send_point(set_x[k], set_y[k], 1'b1, seeded, idx_type'(from), idx_type'(to));
         else
            send_point(set_x[k], set_y[k], 1'b0, 1'($urandom_range(1)),
                       idx_type'($urandom_range(63)), idx_type'($urandom_range(63)));
      end
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic add_point(int x, int y);
      set_x.push_back(coord_type'(x));
      set_y.push_back(coord_type'(y));
   endtask

   // choose the seeding edge and send the set
   task automatic send_with_seed(seed_mode_type mode);
      longint          px[$], py[$];
      vertex_word_type hull[$];
      int              n, k, from, to;
      bit              seeded;
      n = (set_x.size() < MAX_POINTS) ? set_x.size() : MAX_POINTS;
      seeded = (mode != SEED_NONE);
      from = $urandom_range(63);
      to = $urandom_range(63);
      if (mode == SEED_HULL_EDGE) begin
         for (int i = 0; i < n; i++) begin
            px.push_back(longint'(set_x[i]));
            py.push_back(longint'(set_y[i]));
         end
         sb.trace_hull(px, py, 1'b0, 0, 0, hull);
         k = $urandom_range(hull.size() - 1);
         to = hull[k].vtx;
         from = hull[(k + 1) % hull.size()].vtx;
      end else if (mode == SEED_IN_RANGE) begin
         from = $urandom_range(n - 1);
         to = $urandom_range(n - 1);
      end
      send_set(seeded, from, to);
   endtask

   task automatic make_set(int n, cloud_type shape);
      int bx, by;
      set_x = {};
      set_y = {};
      bx = int'($urandom_range(16777087)) - 8388544;
      by = int'($urandom_range(16777087)) - 8388544;
      for (int k = 0; k < n; k++) begin
         case (shape)
            CLOUD_WIDE: begin
               add_point($urandom, $urandom);
            end
            CLOUD_BOX: begin
               add_point(int'($urandom_range(64)) - 32, int'($urandom_range(64)) - 32);
            end
            CLOUD_LATTICE: begin
               add_point((int'($urandom_range(4)) - 2) * 4096,
                         (int'($urandom_range(4)) - 2) * 4096);
            end
            default: begin
               add_point(bx + int'($urandom_range(32)) - 16,
                         by + int'($urandom_range(32)) - 16);
            end
         endcase
      end
   endtask

   // mostly small random sets with random seeding
   task automatic run_random(int target);
      int done, n;
      done = 0;
      while (done < target) begin
         n = ($urandom_range(9) < 2) ? $urandom_range(2, 1) : $urandom_range(10, 3);
         make_set(n, cloud_type'($urandom_range(3)));
         send_with_seed(seed_mode_type'($urandom_range(3)));
         done += n;
      end
   endtask

   // register write once the core is idle
   task automatic write_tolerance(tol_type value);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_tolerance(value);
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single point, unseeded: no successor
      set_x = {}; set_y = {};
      add_point(8388607, -8388608);
      send_set(1'b0, 0, 0);
      // single point, seeded: hull too long at once
      set_x = {}; set_y = {};
      add_point(-8388608, 8388607);
      send_set(1'b1, 0, 0);
      // extreme corners, interior point, repeated corner for the length tie
      set_x = {}; set_y = {};
      add_point(-8388608, -8388608);
      add_point(8388607, -8388608);
      add_point(8388607, 8388607);
      add_point(-8388608, 8388607);
      add_point(0, 0);
      add_point(8388607, 8388607);
      send_set(1'b0, 0, 0);
      // seeded toward an interior point: never returns, hull too long
      set_x = {}; set_y = {};
      add_point(0, 0);
      add_point(4096, 0);
      add_point(4096, 4096);
      add_point(0, 4096);
      add_point(2048, 2048);
      send_set(1'b1, 0, 4);
      // all points coincide
      set_x = {}; set_y = {};
      repeat (3) add_point(100, -100);
      send_set(1'b0, 0, 0);
      // collinear points, seed end out of range falls back to unseeded
      set_x = {}; set_y = {};
      add_point(0, 0);
      add_point(4096, 4096);
      add_point(8192, 8192);
      add_point(-4096, -4096);
      send_set(1'b1, 1, 63);
      // seeded on a true hull edge
      set_x = {}; set_y = {};
      add_point(0, 0);
      add_point(8192, 0);
      add_point(0, 8192);
      add_point(1000, 1000);
      send_with_seed(SEED_HULL_EDGE);

      // random sets across tolerance settings
      write_tolerance('0);
      run_random(90);
      write_tolerance('1);
      run_random(80);
      steady = 1'b1;
      write_tolerance(tol_type'($urandom_range(16777214, 2)));
      run_random(80);
      steady = 1'b0;
      write_tolerance(tol_type'(1));
      // full store, then a set that overflows it
      make_set(MAX_POINTS, CLOUD_WIDE);
      send_with_seed(SEED_HULL_EDGE);
      make_set(MAX_POINTS + 2, CLOUD_WIDE);
      send_with_seed(SEED_NONE);
      run_random(10);

      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
design/cvh_pkg.sv
design/cvh_point_mem.sv
design/cvh_cross_pipe.sv
design/convex_hull_2d_gift_wrap_core.sv
tb/tb_convex_hull_2d_gift_wrap_core.sv
